>>> hdl/rllt_pkg.sv
// Shared types, widths, codes and packing helpers of the resource lease lock table.
package rllt_pkg;

    localparam int LEASE_SLOTS_DEF    = 64;
    localparam int RESOURCE_COUNT_DEF = 5;
    localparam int OWNER_BITS_DEF     = 16;

    localparam int ACTION_W    = 2;
    localparam int REQUESTER_W = 16;
    localparam int MASK_W      = 5;
    localparam int HANDLE_W    = 32;
    localparam int STATUS_W    = 2;
    localparam int GEN_W       = 32;
    localparam int QOWNER_W    = 16;

    localparam int S_TDATA_RAW = REQUESTER_W + 1 + MASK_W + HANDLE_W;
    localparam int S_TDATA_W   = ((S_TDATA_RAW + 7) / 8) * 8;
    localparam int M_TDATA_RAW = STATUS_W + HANDLE_W + 1 + GEN_W + QOWNER_W + HANDLE_W;
    localparam int M_TDATA_W   = ((M_TDATA_RAW + 7) / 8) * 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ACQUIRE = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_QUERY   = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_CONFLICT = 2'd2
    } status_t;

    // Write command to the lease slot store: claim writes the slot, otherwise it is freed.
    typedef struct packed {
        logic                we;
        logic                claim;
        logic [HANDLE_W-1:0] handle;
        logic [MASK_W-1:0]   resources;
    } slot_wr_t;

    // Registered read of one lease slot.
    typedef struct packed {
        logic                used;
        logic [HANDLE_W-1:0] handle;
        logic [MASK_W-1:0]   resources;
    } slot_rd_t;

    function automatic logic [M_TDATA_W-1:0] pack_result(
        input status_t             status,
        input logic [HANDLE_W-1:0] granted,
        input logic                active,
        input logic [GEN_W-1:0]    generation,
        input logic [QOWNER_W-1:0] owner,
        input logic [HANDLE_W-1:0] lease
    );
        logic [M_TDATA_RAW-1:0] raw;
        raw = {lease, owner, generation, active, granted, status};
        return M_TDATA_W'(raw);
    endfunction

endpackage

>>> hdl/rllt_slot_store.sv
// Lease slot store: handle and resource memory with per-slot valid bits and registered read.
module rllt_slot_store #(
    parameter  int LEASE_SLOTS = rllt_pkg::LEASE_SLOTS_DEF,
    localparam int SLOT_IW     = (LEASE_SLOTS > 1) ? $clog2(LEASE_SLOTS) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [SLOT_IW-1:0]   rd_addr,
    input  logic [SLOT_IW-1:0]   wr_addr,
    input  rllt_pkg::slot_wr_t   wr,
    output rllt_pkg::slot_rd_t   rd
);

    localparam int WORD_W = rllt_pkg::HANDLE_W + rllt_pkg::MASK_W;

    logic [WORD_W-1:0]      mem [LEASE_SLOTS];
    logic [LEASE_SLOTS-1:0] used_reg;
    logic [WORD_W-1:0]      rd_word_reg;
    logic                   rd_used_reg;

    // Entry contents are only ever read while the slot's valid bit is set.
    always_ff @(posedge aclk) begin
        if (wr.we && wr.claim) begin
            mem[wr_addr] <= {wr.handle, wr.resources};
        end
        rd_word_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= '0;
            rd_used_reg <= 1'b0;
        end else begin
            if (wr.we) begin
                used_reg[wr_addr] <= wr.claim;
            end
            rd_used_reg <= used_reg[rd_addr];
        end
    end

    assign rd.used      = rd_used_reg;
    assign rd.handle    = rd_word_reg[WORD_W-1:rllt_pkg::MASK_W];
    assign rd.resources = rd_word_reg[rllt_pkg::MASK_W-1:0];

endmodule

>>> hdl/resource_lease_lock_table_unit.sv
// Top level of the resource lease lock table: request decode, slot walk and resource state.
//
// Channel  Dir  Handshake            Payload
// s_       in   s_tvalid / s_tready  s_tuser action, s_tdata request arguments
// m_       out  m_tvalid / m_tready  m_tdata status, granted handle and query fields
//
// A query, a rejected request or a conflict on an owned resource is answered straight from
// the evaluation step without a walk. Acquire and release walk the lease slot memory, one
// slot per cycle through its single read port, until a hit or the last slot is checked.
// One request is worked on at a time; the next is taken once the result sits in the output
// register, even while that result is still stalled by m_tready.
// Reset is synchronous and active low; the slot valid bits clear at once, so no clearing
// pass is needed and the block takes requests as soon as reset is released.
module resource_lease_lock_table_unit #(
    parameter int LEASE_SLOTS    = rllt_pkg::LEASE_SLOTS_DEF,
    parameter int RESOURCE_COUNT = rllt_pkg::RESOURCE_COUNT_DEF,
    parameter int OWNER_BITS     = rllt_pkg::OWNER_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata, from bit 0: requester[15:0], requester_known, res_select[4:0],
    // lease_handle[31:0], zero padding.
    input  logic [rllt_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: action[1:0].
    input  logic [rllt_pkg::ACTION_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata, from bit 0: status[1:0], granted_handle[31:0], query_active,
    // query_generation[31:0], query_owner[15:0], query_lease[31:0], zero padding.
    output logic [rllt_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int SLOT_IW = (LEASE_SLOTS > 1) ? $clog2(LEASE_SLOTS) : 1;
    localparam int RES_IW  = (RESOURCE_COUNT > 1) ? $clog2(RESOURCE_COUNT) : 1;
    localparam logic [SLOT_IW-1:0] SLOT_LAST = SLOT_IW'(LEASE_SLOTS - 1);

    localparam int HW = rllt_pkg::HANDLE_W;
    localparam int MW = rllt_pkg::MASK_W;
    localparam int GW = rllt_pkg::GEN_W;

    typedef enum logic [1:0] {
        IDLE,
        EVAL,
        SCAN,
        RESP
    } state_t;

    state_t state_reg;

    // Request held for the length of its processing.
    rllt_pkg::action_t              req_action_reg;
    logic [rllt_pkg::REQUESTER_W-1:0] req_requester_reg;
    logic                           req_known_reg;
    logic [MW-1:0]                  req_mask_reg;
    logic [HW-1:0]                  req_handle_reg;

    // Per-resource lock state, held in flip-flops so that all entries can be checked at once.
    logic [OWNER_BITS-1:0] res_owner_reg [RESOURCE_COUNT];
    logic [HW-1:0]         res_lease_reg [RESOURCE_COUNT];
    logic [GW-1:0]         res_gen_reg   [RESOURCE_COUNT];
    logic [HW-1:0]         next_handle_reg;

    // Slot walk: reads are issued at idx_reg and checked in the following cycle at chk_idx_reg.
    logic [SLOT_IW-1:0] idx_reg;
    logic [SLOT_IW-1:0] chk_idx_reg;
    logic               issue_on_reg;
    logic               chk_valid_reg;

    logic [rllt_pkg::M_TDATA_W-1:0] res_data_reg;
    logic [rllt_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                           m_tvalid_reg;

    rllt_pkg::slot_rd_t slot_rd;
    rllt_pkg::slot_wr_t slot_wr;

    logic                      s_xfer;
    logic                      out_load;
    logic [RESOURCE_COUNT-1:0] want_acq;
    logic [RESOURCE_COUNT-1:0] want_rel;
    logic                      foreign;
    logic                      acq_invalid;
    logic                      conflict;
    logic                      query_ok;
    logic [RES_IW-1:0]         q_idx;
    logic                      hit;
    logic                      scan_end;
    logic                      grant;
    logic                      release_hit;
    logic [HW-1:0]             issue_h;
    logic [OWNER_BITS-1:0]     own_in;
    logic [OWNER_BITS-1:0]     q_owner;

    assign s_tready = (state_reg == IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The finished result moves into the output register once that register is free or
    // its current transfer completes in the same cycle.
    assign out_load = (state_reg == RESP) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            req_action_reg    <= rllt_pkg::action_t'(s_tuser);
            req_requester_reg <= s_tdata[rllt_pkg::REQUESTER_W-1:0];
            req_known_reg     <= s_tdata[rllt_pkg::REQUESTER_W];
            req_mask_reg      <= s_tdata[rllt_pkg::REQUESTER_W+1 +: MW];
            req_handle_reg    <= s_tdata[rllt_pkg::REQUESTER_W+1+MW +: HW];
        end
    end

    // Request decode. Mask bits at or above RESOURCE_COUNT name no resource.
    always_comb begin
        want_acq = RESOURCE_COUNT'(req_mask_reg);
        want_rel = RESOURCE_COUNT'(slot_rd.resources);
        own_in   = OWNER_BITS'(req_requester_reg);
        foreign  = 1'b0;
        for (int b = 0; b < MW; b++) begin
            if (req_mask_reg[b] && (b >= RESOURCE_COUNT)) begin
                foreign = 1'b1;
            end
        end
        acq_invalid = (req_mask_reg == '0) || foreign || !req_known_reg;
        conflict    = 1'b0;
        for (int r = 0; r < RESOURCE_COUNT; r++) begin
            if (want_acq[r] && (res_owner_reg[r] != '0)) begin
                conflict = 1'b1;
            end
        end
        query_ok = $onehot(req_mask_reg) && !foreign;
        q_idx    = '0;
        for (int b = 0; b < MW; b++) begin
            if (req_mask_reg[b]) begin
                q_idx = RES_IW'(b);
            end
        end
        q_owner = res_owner_reg[q_idx];
    end

    // A free slot ends an acquire walk; a used slot with the same handle ends a release walk.
    always_comb begin
        if (req_action_reg == rllt_pkg::ACT_ACQUIRE) begin
            hit = chk_valid_reg && !slot_rd.used;
        end else begin
            hit = chk_valid_reg && slot_rd.used && (slot_rd.handle == req_handle_reg);
        end
        scan_end    = chk_valid_reg && (chk_idx_reg == SLOT_LAST) && !hit;
        grant       = (state_reg == SCAN) && hit && (req_action_reg == rllt_pkg::ACT_ACQUIRE);
        release_hit = (state_reg == SCAN) && hit && (req_action_reg == rllt_pkg::ACT_RELEASE);
        // The handle counter skips zero when it wraps.
        issue_h     = (next_handle_reg == '0) ? next_handle_reg + HW'(1) : next_handle_reg;
    end

    // The slot write lands at the end of the walk; the next walk issues its first read only after
    // the response, idle and evaluation states, so no forwarding around the memory is needed.
    always_comb begin
        slot_wr.we        = grant || release_hit;
        slot_wr.claim     = grant;
        slot_wr.handle    = issue_h;
        slot_wr.resources = req_mask_reg;
    end

    rllt_slot_store #(
        .LEASE_SLOTS (LEASE_SLOTS)
    ) u_slot_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (idx_reg),
        .wr_addr (chk_idx_reg),
        .wr      (slot_wr),
        .rd      (slot_rd)
    );

    // Resource state. A release clears only those resources whose lease is still its own.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < RESOURCE_COUNT; r++) begin
                res_owner_reg[r] <= '0;
                res_lease_reg[r] <= '0;
                res_gen_reg[r]   <= GW'(1);
            end
            next_handle_reg <= HW'(1);
        end else begin
            if (grant) begin
                for (int r = 0; r < RESOURCE_COUNT; r++) begin
                    if (want_acq[r]) begin
                        res_owner_reg[r] <= own_in;
                        res_lease_reg[r] <= issue_h;
                        res_gen_reg[r]   <= res_gen_reg[r] + GW'(1);
                    end
                end
                next_handle_reg <= issue_h + HW'(1);
            end
            if (release_hit) begin
                for (int r = 0; r < RESOURCE_COUNT; r++) begin
                    if (want_rel[r] && (res_lease_reg[r] == req_handle_reg)) begin
                        res_owner_reg[r] <= '0;
                        res_lease_reg[r] <= '0;
                        res_gen_reg[r]   <= res_gen_reg[r] + GW'(1);
                    end
                end
            end
        end
    end

    // Sequencer with the walk counters and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= IDLE;
            m_tvalid_reg  <= 1'b0;
            issue_on_reg  <= 1'b0;
            chk_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_tdata_reg  <= res_data_reg;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE: begin
                    if (s_xfer) begin
                        state_reg <= EVAL;
                    end
                end
                EVAL: begin
                    idx_reg       <= '0;
                    issue_on_reg  <= 1'b1;
                    chk_valid_reg <= 1'b0;
                    unique case (req_action_reg)
                        rllt_pkg::ACT_ACQUIRE: begin
                            if (acq_invalid) begin
                                res_data_reg <= rllt_pkg::pack_result(rllt_pkg::ST_INVALID,
                                                                      '0, 1'b0, '0, '0, '0);
                                state_reg    <= RESP;
                            end else if (conflict) begin
                                res_data_reg <= rllt_pkg::pack_result(rllt_pkg::ST_CONFLICT,
                                                                      '0, 1'b0, '0, '0, '0);
                                state_reg    <= RESP;
                            end else begin
                                state_reg <= SCAN;
                            end
                        end
                        rllt_pkg::ACT_RELEASE: begin
                            if (req_handle_reg != '0) begin
                                state_reg <= SCAN;
                            end else begin
                                res_data_reg <= rllt_pkg::pack_result(rllt_pkg::ST_INVALID,
                                                                      '0, 1'b0, '0, '0, '0);
                                state_reg    <= RESP;
                            end
                        end
                        rllt_pkg::ACT_QUERY: begin
                            if (query_ok) begin
                                res_data_reg <= rllt_pkg::pack_result(
                                    rllt_pkg::ST_OK, '0, (q_owner != '0), res_gen_reg[q_idx],
                                    rllt_pkg::QOWNER_W'(q_owner), res_lease_reg[q_idx]);
                            end else begin
                                res_data_reg <= rllt_pkg::pack_result(rllt_pkg::ST_INVALID,
                                                                      '0, 1'b0, '0, '0, '0);
                            end
                            state_reg <= RESP;
                        end
                        default: begin
                            // The unused action code is answered as invalid.
                            res_data_reg <= rllt_pkg::pack_result(rllt_pkg::ST_INVALID,
                                                                  '0, 1'b0, '0, '0, '0);
                            state_reg    <= RESP;
                        end
                    endcase
                end
                SCAN: begin
                    chk_valid_reg <= issue_on_reg;
                    chk_idx_reg   <= idx_reg;
                    if (issue_on_reg) begin
                        if (idx_reg == SLOT_LAST) begin
                            issue_on_reg <= 1'b0;
                        end else begin
                            idx_reg <= idx_reg + SLOT_IW'(1);
                        end
                    end
                    if (grant) begin
                        res_data_reg <= rllt_pkg::pack_result(rllt_pkg::ST_OK, issue_h, 1'b0,
                                                              '0, '0, '0);
                        state_reg    <= RESP;
                    end else if (release_hit) begin
                        res_data_reg <= rllt_pkg::pack_result(rllt_pkg::ST_OK, '0, 1'b0,
                                                              '0, '0, '0);
                        state_reg    <= RESP;
                    end else if (scan_end) begin
                        if (req_action_reg == rllt_pkg::ACT_ACQUIRE) begin
                            res_data_reg <= rllt_pkg::pack_result(rllt_pkg::ST_CONFLICT, '0,
                                                                  1'b0, '0, '0, '0);
                        end else begin
                            res_data_reg <= rllt_pkg::pack_result(rllt_pkg::ST_INVALID, '0,
                                                                  1'b0, '0, '0, '0);
                        end
                        state_reg <= RESP;
                    end
                end
                RESP: begin
                    if (out_load) begin
                        state_reg <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    // A nonzero granted handle comes only with a successful status.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[rllt_pkg::STATUS_W +: HW] != '0)
            |-> (m_tdata[rllt_pkg::STATUS_W-1:0] == rllt_pkg::ST_OK))
        else $error("granted handle on a failed request");

    // Any failed request returns all result fields but the status as zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[rllt_pkg::STATUS_W-1:0] != rllt_pkg::ST_OK)
            |-> (m_tdata[rllt_pkg::M_TDATA_W-1:rllt_pkg::STATUS_W] == '0))
        else $error("failed request carries result fields");

    // A lease slot is never claimed with the reserved handle zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        slot_wr.we && slot_wr.claim |-> (slot_wr.handle != '0))
        else $error("slot claimed with handle zero");

    // A new result appears only after the sequencer has passed through its response state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == RESP))
        else $error("result presented outside the response state");

endmodule

>>> tb/sv/lease_book_pkg.sv
`timescale 1ns / 100ps
// Scoreboard class that mirrors the lease lock table and checks its results in order.
package lease_book_pkg;

    import rllt_pkg::*;

    // The action code that the block leaves unused; it must be answered as invalid.
    localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

    // Declared from the most significant field down, so that it overlays m_tdata directly.
    typedef struct packed {
        logic [HANDLE_W-1:0] lease;
        logic [QOWNER_W-1:0] owner;
        logic [GEN_W-1:0]    generation;
        logic                active;
        logic [HANDLE_W-1:0] granted;
        status_t             status;
    } lease_reply_t;

    class lease_ledger;
        logic                slot_used   [LEASE_SLOTS_DEF];
        logic [HANDLE_W-1:0] slot_handle [LEASE_SLOTS_DEF];
        logic [MASK_W-1:0]   slot_mask   [LEASE_SLOTS_DEF];
        logic [QOWNER_W-1:0] res_owner   [RESOURCE_COUNT_DEF];
        logic [HANDLE_W-1:0] res_lease   [RESOURCE_COUNT_DEF];
        logic [GEN_W-1:0]    res_gen     [RESOURCE_COUNT_DEF];
        logic [HANDLE_W-1:0] handle_counter;
        lease_reply_t        awaited[$];
        int unsigned         faults;

        function new();
            foreach (slot_used[s]) begin
                slot_used[s]   = 1'b0;
                slot_handle[s] = '0;
                slot_mask[s]   = '0;
            end
            foreach (res_owner[r]) begin
                res_owner[r] = '0;
                res_lease[r] = '0;
                res_gen[r]   = 1;
            end
            handle_counter = 1;
            faults         = 0;
        endfunction

        // Works out the reply to one accepted request and updates the mirrored table.
        function void note_request(input logic [ACTION_W-1:0] act,
                                   input logic [S_TDATA_W-1:0] data);
            logic [REQUESTER_W-1:0] who;
            logic                   known;
            logic [MASK_W-1:0]      mask;
            logic [HANDLE_W-1:0]    handle;
            lease_reply_t           rep;
            logic                   taken;
            int                     slot;
            who    = data[REQUESTER_W-1:0];
            known  = data[REQUESTER_W];
            mask   = data[REQUESTER_W+1 +: MASK_W];
            handle = data[REQUESTER_W+1+MASK_W +: HANDLE_W];
            rep        = '0;
            rep.status = ST_INVALID;
            slot       = -1;
            taken      = 1'b0;
            case (act)
                ACT_ACQUIRE: begin
                    if (mask != 0 && known && (mask >> RESOURCE_COUNT_DEF) == 0) begin
                        for (int r = 0; r < RESOURCE_COUNT_DEF; r++)
                            if (mask[r] && res_owner[r] != 0) taken = 1'b1;
                        for (int s = 0; s < LEASE_SLOTS_DEF; s++)
                            if (!slot_used[s] && slot < 0) slot = s;
                        if (taken || slot < 0) begin
                            rep.status = ST_CONFLICT;
                        end else begin
                            // The handle counter skips zero when it wraps.
                            rep.granted    = handle_counter;
                            handle_counter = handle_counter + 1;
                            if (rep.granted == 0) begin
                                rep.granted    = handle_counter;
                                handle_counter = handle_counter + 1;
                            end
                            slot_used[slot]   = 1'b1;
                            slot_handle[slot] = rep.granted;
                            slot_mask[slot]   = mask;
                            for (int r = 0; r < RESOURCE_COUNT_DEF; r++) begin
                                if (mask[r]) begin
                                    res_owner[r] = who;
                                    res_lease[r] = rep.granted;
                                    res_gen[r]   = res_gen[r] + 1;
                                end
                            end
                            rep.status = ST_OK;
                        end
                    end
                end
                ACT_RELEASE: begin
                    for (int s = 0; s < LEASE_SLOTS_DEF; s++)
                        if (slot_used[s] && slot_handle[s] == handle && slot < 0) slot = s;
                    if (handle != 0 && slot >= 0) begin
                        // Only resources not since taken over by a newer lease are cleared.
                        for (int r = 0; r < RESOURCE_COUNT_DEF; r++) begin
                            if (slot_mask[slot][r] && res_lease[r] == handle) begin
                                res_owner[r] = '0;
                                res_lease[r] = '0;
                                res_gen[r]   = res_gen[r] + 1;
                            end
                        end
                        slot_used[slot]   = 1'b0;
                        slot_handle[slot] = '0;
                        slot_mask[slot]   = '0;
                        rep.status        = ST_OK;
                    end
                end
                ACT_QUERY: begin
                    for (int r = 0; r < RESOURCE_COUNT_DEF; r++) begin
                        if (mask == (MASK_W'(1) << r)) begin
                            rep.status     = ST_OK;
                            rep.active     = res_owner[r] != 0;
                            rep.generation = res_gen[r];
                            rep.owner      = res_owner[r];
                            rep.lease      = res_lease[r];
                        end
                    end
                end
                default: ;
            endcase
            awaited.push_back(rep);
        endfunction

        function void check_reply(input logic [M_TDATA_W-1:0] data);
            lease_reply_t got;
            lease_reply_t want;
            got = lease_reply_t'(data[M_TDATA_RAW-1:0]);
            if (awaited.size() == 0) begin
                faults++;
                if (faults <= 10) $display("Result transfer with nothing awaited: %h", data);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status || got.granted !== want.granted ||
                got.active !== want.active || got.generation !== want.generation ||
                got.owner !== want.owner || got.lease !== want.lease) begin
                faults++;
                if (faults <= 10) begin
                    $display("Mismatch at %0t: expected status %0d handle %h active %b gen %h owner %h lease %h",
                             $realtime, want.status, want.granted, want.active,
                             want.generation, want.owner, want.lease);
                    $display("               actual   status %0d handle %h active %b gen %h owner %h lease %h",
                             got.status, got.granted, got.active,
                             got.generation, got.owner, got.lease);
                end
            end
        endfunction

        function int live_leases();
            int n;
            n = 0;
            foreach (slot_used[s]) if (slot_used[s]) n++;
            return n;
        endfunction

        // A handle held by some live lease, or zero when the table is empty.
        function logic [HANDLE_W-1:0] some_live_handle();
            int idx[$];
            foreach (slot_used[s]) if (slot_used[s]) idx.push_back(s);
            if (idx.size() == 0) return '0;
            return slot_handle[idx[$urandom_range(0, idx.size() - 1)]];
        endfunction
    endclass

endpackage

>>> tb/sv/tb_resource_lease_lock_table_unit.sv
`timescale 1ns / 100ps
// Top of the testbench for the resource lease lock table: stimulus, flow control and ending.
module tb_resource_lease_lock_table_unit;

    import rllt_pkg::*;
    import lease_book_pkg::*;

    // The slowest request walks all slots; the tail is sized to cover one full walk.
    localparam int          TAIL_CYCLES      = LEASE_SLOTS_DEF + 16;
    // Room for about 1750 requests, each at worst one full walk, taken several times over.
    localparam int unsigned CYCLE_LIMIT      = 1_000_000;
    localparam int          ROUNDS           = 3;
    localparam int          RANDOM_PER_ROUND = 420;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [ACTION_W-1:0]  s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    lease_ledger book = new();

    int unsigned burst_left  = 0;
    int unsigned rx_left     = 0;
    int unsigned rx_mode     = 0;
    int unsigned rx_tick     = 0;
    int unsigned cycle_count = 0;

    resource_lease_lock_table_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Every result transfer is checked against the oldest outstanding prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) book.check_reply(m_tdata);
    end

    // The receiver switches between stretches of different stall patterns: always ready,
    // coin-toss, and two periodic patterns, one short and one long, of stalls between single transfers.
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(40, 400);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (rx_tick % 4) == 0;
            default: m_tready <= (rx_tick % 24) == 0;
        endcase
    end

    // Watchdog: a hung block or a lost result ends the run here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offers one request and returns once it has been accepted. The sender works in bursts;
    // between bursts tvalid is held low for a random gap, sometimes none at all. Within a
    // burst tvalid stays high from one transfer to the next.
    task automatic send_request(input logic [ACTION_W-1:0]    act,
                                input logic [REQUESTER_W-1:0] who,
                                input logic                   known,
                                input logic [MASK_W-1:0]      mask,
                                input logic [HANDLE_W-1:0]    handle);
        logic [S_TDATA_W-1:0] word;
        int unsigned          gap;
        word = S_TDATA_W'({handle, mask, known, who});
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 4))
                0, 1:    gap = 0;
                2, 3:    gap = $urandom_range(1, 4);
                default: gap = $urandom_range(5, 20);
            endcase
            if (gap != 0) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = act;
        s_tdata  = word;
        do @(posedge aclk); while (!s_tready);
        book.note_request(act, word);
    endtask

    // Holds the sender off until every outstanding result has been transferred.
    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (book.awaited.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [MASK_W-1:0] any_one_hot();
        return MASK_W'(1) << $urandom_range(0, RESOURCE_COUNT_DEF - 1);
    endfunction

    // One request of the random mix: mostly well-formed acquires, releases of live leases
    // and one-hot queries, with malformed requests and the spare action mixed in.
    task automatic random_request();
        int unsigned            pick;
        logic [REQUESTER_W-1:0] who;
        logic [MASK_W-1:0]      mask;
        logic [HANDLE_W-1:0]    handle;
        pick   = $urandom_range(0, 99);
        who    = REQUESTER_W'($urandom);
        mask   = MASK_W'($urandom);
        handle = $urandom;
        if (pick < 40) begin
            // Requester zero is common, since its claims leave the resources reading as free.
            if ($urandom_range(0, 3) == 0) who = '0;
            case ($urandom_range(0, 9))
                0:             mask = '0;
                1, 2, 3, 4, 5: mask = any_one_hot();
                default:       mask = MASK_W'($urandom_range(1, 31));
            endcase
            send_request(ACT_ACQUIRE, who, $urandom_range(0, 9) != 0, mask, handle);
        end else if (pick < 70) begin
            case ($urandom_range(0, 19))
                14, 15:  handle = '0;
                16, 17:  handle = book.handle_counter - $urandom_range(1, 6);
                18, 19:  ;
                default: handle = book.some_live_handle();
            endcase
            send_request(ACT_RELEASE, who, 1'($urandom), mask, handle);
        end else if (pick < 95) begin
            if ($urandom_range(0, 6) != 0) mask = any_one_hot();
            send_request(ACT_QUERY, who, 1'($urandom), mask, handle);
        end else begin
            send_request(ACT_SPARE, who, 1'($urandom), mask, handle);
        end
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // Directed opening. Handles are issued from one upwards, so they are known here.
        send_request(ACT_QUERY,   16'h0000, 1'b0, 5'b00001, 32'h0);        // reset state
        send_request(ACT_ACQUIRE, 16'h1234, 1'b1, 5'b00000, 32'h0);        // empty mask
        send_request(ACT_ACQUIRE, 16'h1234, 1'b0, 5'b00001, 32'h0);        // unknown client
        send_request(ACT_ACQUIRE, 16'hFFFF, 1'b1, 5'b11111, 32'hFFFFFFFF); // all, handle 1
        send_request(ACT_ACQUIRE, 16'h0001, 1'b1, 5'b00001, 32'h0);        // owned resource
        send_request(ACT_QUERY,   16'hFFFF, 1'b1, 5'b10000, 32'hFFFFFFFF);
        send_request(ACT_QUERY,   16'h0000, 1'b0, 5'b00000, 32'h0);        // not one-hot
        send_request(ACT_QUERY,   16'h0000, 1'b0, 5'b00011, 32'h0);
        send_request(ACT_QUERY,   16'h0000, 1'b0, 5'b11111, 32'h0);
        send_request(ACT_RELEASE, 16'h0000, 1'b0, 5'b00000, 32'h0);        // zero handle
        send_request(ACT_RELEASE, 16'hFFFF, 1'b1, 5'b11111, 32'hFFFFFFFF); // unknown handle
        send_request(ACT_RELEASE, 16'h0000, 1'b0, 5'b00000, 32'h1);
        send_request(ACT_RELEASE, 16'h0000, 1'b0, 5'b00000, 32'h1);        // released twice
        send_request(ACT_SPARE,   16'hFFFF, 1'b1, 5'b11111, 32'hFFFFFFFF);
        // Claims by requester zero leave the resources free for anyone to claim again.
        send_request(ACT_ACQUIRE, 16'h0000, 1'b1, 5'b00110, 32'h0);        // handle 2
        send_request(ACT_QUERY,   16'h0000, 1'b0, 5'b00010, 32'h0);
        send_request(ACT_ACQUIRE, 16'h0000, 1'b1, 5'b00010, 32'h0);        // handle 3
        send_request(ACT_ACQUIRE, 16'h8001, 1'b1, 5'b10010, 32'h0);        // handle 4
        // Releasing handle 2 clears only the resource that it still holds.
        send_request(ACT_RELEASE, 16'h0000, 1'b0, 5'b00000, 32'h2);
        send_request(ACT_QUERY,   16'h0000, 1'b0, 5'b00010, 32'h0);
        send_request(ACT_QUERY,   16'h0000, 1'b0, 5'b00100, 32'h0);
        send_request(ACT_RELEASE, 16'h0000, 1'b0, 5'b00000, 32'h4);
        send_request(ACT_RELEASE, 16'h0000, 1'b0, 5'b00000, 32'h3);

        for (int round = 0; round < ROUNDS; round++) begin
            // Empty the table through releases of the live leases, then let it go quiet.
            while (book.live_leases() != 0) begin
                if ($urandom_range(0, 6) == 0)
                    send_request(ACT_QUERY, '0, 1'b0, any_one_hot(), $urandom);
                else
                    send_request(ACT_RELEASE, REQUESTER_W'($urandom), 1'b0, '0,
                                 book.some_live_handle());
            end
            settle();
            // Fill every slot with requester-zero leases; the last few find the table full.
            repeat (LEASE_SLOTS_DEF + 6) begin
                if ($urandom_range(0, 9) == 0)
                    send_request(ACT_QUERY, '0, 1'b0, any_one_hot(), $urandom);
                send_request(ACT_ACQUIRE, '0, 1'b1, MASK_W'($urandom_range(1, 31)), $urandom);
            end
            repeat (RANDOM_PER_ROUND) random_request();
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (book.faults == 0 && book.awaited.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> resource_lease_lock_table_unit.f
hdl/rllt_pkg.sv
hdl/rllt_slot_store.sv
hdl/resource_lease_lock_table_unit.sv
tb/sv/lease_book_pkg.sv
tb/sv/tb_resource_lease_lock_table_unit.sv
